@@ design/pstc_pkg.sv @@
// ----------------------------------------------------------------------------
// pstc_pkg: shared types and constants for the sensor compensation pipeline
// Holds the decoded calibration set, the per-beat side data and the fixed
// constants of the integer compensation scheme.
// ----------------------------------------------------------------------------
package pstc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAL_T1_T2 = 3'd0,
    REG_CAL_T3_P1 = 3'd1,
    REG_CAL_P2_P3 = 3'd2,
    REG_CAL_P4_P5 = 3'd3,
    REG_CAL_P6_P7 = 3'd4,
    REG_CAL_P8_P9 = 3'd5
  } cfg_reg_t;

  // Decoded calibration coefficients.
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Data that rides along with a beat through the pressure path.
  typedef struct packed {
    logic signed [31:0] tcenti;
    logic               err;
  } side_t;

  // Pressure-stage constants.
  localparam logic signed [32:0] PressOffset = 33'sd128000;
  localparam logic        [20:0] PressFull   = 21'd1048576;
  localparam logic        [11:0] PressScale  = 12'd3125;
  localparam int unsigned        W1BiasShift = 47;
  localparam int unsigned        W1Shift     = 33;
  localparam int unsigned        P4Shift     = 35;

  // One quotient bit per divider stage.
  localparam int unsigned DivSteps = 64;

endpackage

@@ design/pstc_temp.sv @@
// ----------------------------------------------------------------------------
// pstc_temp: temperature compensation pipeline
// Five register stages of 32-bit arithmetic; delivers the offset fine
// temperature for the pressure path and the temperature in centidegrees.
// ----------------------------------------------------------------------------
module pstc_temp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [19:0]        raw_t,
  input  logic [19:0]        raw_p,
  input  pstc_pkg::cal_t     cal,
  output logic               out_valid,
  output logic signed [32:0] x,
  output logic signed [31:0] tcenti,
  output logic [19:0]        rp
);

  localparam int Stages = 5;

  logic [Stages-1:0]  v_r;
  logic [19:0]        rp_r [Stages];
  logic signed [17:0] a_r, a_nxt, d_r, d_nxt;
  logic signed [33:0] m1_full;
  logic signed [35:0] dd_full;
  logic signed [31:0] m1_r, dd_r, m1_sh, dd_sh;
  logic signed [20:0] v1_r, v1_nxt;
  logic signed [19:0] ddq;
  logic signed [35:0] m2_full;
  logic signed [31:0] m2_r, m2_sh;
  logic signed [17:0] v2;
  logic signed [31:0] tfine_r, tfine_nxt, t5, tc_sh, tcenti_r;
  logic signed [32:0] x_r, x_nxt;

  // Stage logic; every product wraps to 32 bits as in the scheme.
  always_comb begin
    a_nxt     = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    d_nxt     = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, cal.t1});
    m1_full   = a_r * cal.t2;
    dd_full   = d_r * d_r;
    m1_sh     = m1_r >>> 11;
    v1_nxt    = m1_sh[20:0];
    dd_sh     = dd_r >>> 12;
    ddq       = dd_sh[19:0];
    m2_full   = ddq * cal.t3;
    m2_sh     = m2_r >>> 14;
    v2        = m2_sh[17:0];
    tfine_nxt = {{11{v1_r[20]}}, v1_r} + {{14{v2[17]}}, v2};
    t5        = tfine_r + (tfine_r <<< 2) + 32'sd128;
    tc_sh     = t5 >>> 8;
    x_nxt     = {tfine_r[31], tfine_r} - pstc_pkg::PressOffset;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      d_r      <= d_nxt;
      m1_r     <= m1_full[31:0];
      dd_r     <= dd_full[31:0];
      v1_r     <= v1_nxt;
      m2_r     <= m2_full[31:0];
      tfine_r  <= tfine_nxt;
      tcenti_r <= tc_sh;
      x_r      <= x_nxt;
      rp_r[0]  <= raw_p;
      for (int i = 1; i < Stages; i++) begin
        rp_r[i] <= rp_r[i-1];
      end
    end
  end

  assign out_valid = v_r[Stages-1];
  assign x         = x_r;
  assign tcenti    = tcenti_r;
  assign rp        = rp_r[Stages-1];

endmodule

@@ design/pstc_coef.sv @@
// ----------------------------------------------------------------------------
// pstc_coef: pressure coefficient pipeline
// Seven stages of 64-bit modular arithmetic built from 32-bit partial
// products; produces the dividend, the divisor and the zero-divisor flag.
// ----------------------------------------------------------------------------
module pstc_coef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [32:0] x,
  input  logic signed [31:0] tcenti,
  input  logic [19:0]        rp,
  input  pstc_pkg::cal_t     cal,
  output logic               out_valid,
  output logic [63:0]        num,
  output logic signed [30:0] den,
  output pstc_pkg::side_t    side
);

  localparam int Stages = 7;

  logic [Stages-1:0]  v_r;
  logic signed [31:0] tc_r [Stages];
  logic [19:0]        rp_r [4];

  logic [32:0]        absx;
  logic [63:0]        sq_r, sq_nxt;
  logic signed [48:0] xp5_r, xp5_nxt, xp2_r, xp2_nxt;
  logic signed [48:0] a6_r, a6_nxt, a3_r, a3_nxt, b6_full, b3_full;
  logic [31:0]        b6_r, b3_r;
  logic signed [48:0] xp5_c2_r, xp2_c2_r, xp5_c3_r, xp2_c3_r;
  logic [63:0]        sqp6_r, sqp6_nxt;
  logic signed [63:0] sqp3_r, sqp3_nxt, sqp3_sh;
  logic [63:0]        w2_r, w2_nxt, w1b_r, w1b_nxt;
  logic [47:0]        lop1_r, lop1_nxt, hip1_full;
  logic [31:0]        hip1_r;
  logic [20:0]        pn;
  logic [63:0]        numpre_r, numpre_nxt;
  logic signed [63:0] w1c, w1_sh;
  logic signed [30:0] den_r, den_nxt, den2_r;
  logic [43:0]        nl_r, nl_nxt, nh_full;
  logic [31:0]        nh_r;
  logic [63:0]        num_r, num_nxt;
  logic               err_r, err_nxt;

  always_comb begin
    // Square of the offset temperature and its linear terms.
    absx     = x[32] ? (~x + 33'd1) : x;
    sq_nxt   = absx[31:0] * absx[31:0];
    xp5_nxt  = x * cal.p5;
    xp2_nxt  = x * cal.p2;
    // Square times P6 and P3 as low and high partial products.
    a6_nxt   = $signed({1'b0, sq_r[31:0]}) * cal.p6;
    b6_full  = $signed({1'b0, sq_r[63:32]}) * cal.p6;
    a3_nxt   = $signed({1'b0, sq_r[31:0]}) * cal.p3;
    b3_full  = $signed({1'b0, sq_r[63:32]}) * cal.p3;
    sqp6_nxt = {{15{a6_r[48]}}, a6_r} + {b6_r, 32'h0};
    sqp3_nxt = {{15{a3_r[48]}}, a3_r} + {b3_r, 32'h0};
    // Collect the two polynomial sums.
    w2_nxt   = sqp6_r + ({{15{xp5_c3_r[48]}}, xp5_c3_r} << 17)
             + ({{48{cal.p4[15]}}, cal.p4} << pstc_pkg::P4Shift);
    sqp3_sh  = sqp3_r >>> 8;
    w1b_nxt  = sqp3_sh + ({{15{xp2_c3_r[48]}}, xp2_c3_r} << 12)
             + (64'd1 << pstc_pkg::W1BiasShift);
    // Scale by P1 and start the dividend.
    lop1_nxt  = w1b_r[31:0] * cal.p1;
    hip1_full = w1b_r[63:32] * cal.p1;
    pn        = pstc_pkg::PressFull - {1'b0, rp_r[3]};
    numpre_nxt = {12'b0, pn, 31'b0} - w2_r;
    // Divisor and dividend times the scale factor.
    w1c     = {16'b0, lop1_r} + {hip1_r, 32'h0};
    w1_sh   = w1c >>> pstc_pkg::W1Shift;
    den_nxt = w1_sh[30:0];
    nl_nxt  = numpre_r[31:0] * pstc_pkg::PressScale;
    nh_full = numpre_r[63:32] * pstc_pkg::PressScale;
    num_nxt = {20'b0, nl_r} + {nh_r, 32'h0};
    err_nxt = (den_r == '0);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= sq_nxt;
      xp5_r    <= xp5_nxt;
      xp2_r    <= xp2_nxt;
      a6_r     <= a6_nxt;
      b6_r     <= b6_full[31:0];
      a3_r     <= a3_nxt;
      b3_r     <= b3_full[31:0];
      xp5_c2_r <= xp5_r;
      xp2_c2_r <= xp2_r;
      sqp6_r   <= sqp6_nxt;
      sqp3_r   <= sqp3_nxt;
      xp5_c3_r <= xp5_c2_r;
      xp2_c3_r <= xp2_c2_r;
      w2_r     <= w2_nxt;
      w1b_r    <= w1b_nxt;
      lop1_r   <= lop1_nxt;
      hip1_r   <= hip1_full[31:0];
      numpre_r <= numpre_nxt;
      den_r    <= den_nxt;
      nl_r     <= nl_nxt;
      nh_r     <= nh_full[31:0];
      num_r    <= num_nxt;
      den2_r   <= den_r;
      err_r    <= err_nxt;
      rp_r[0]  <= rp;
      for (int i = 1; i < 4; i++) begin
        rp_r[i] <= rp_r[i-1];
      end
      tc_r[0] <= tcenti;
      for (int i = 1; i < Stages; i++) begin
        tc_r[i] <= tc_r[i-1];
      end
    end
  end

  assign out_valid   = v_r[Stages-1];
  assign num         = num_r;
  assign den         = den2_r;
  assign side.tcenti = tc_r[Stages-1];
  assign side.err    = err_r;

endmodule

@@ design/pstc_div.sv @@
// ----------------------------------------------------------------------------
// pstc_div: pipelined signed 64-bit divider
// Sign stripping, one restoring step per stage for all quotient bits, then
// sign restore. Quotients truncate toward zero.
// ----------------------------------------------------------------------------
module pstc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        num,
  input  logic signed [30:0] den,
  input  pstc_pkg::side_t    side_in,
  output logic               out_valid,
  output logic signed [63:0] quo,
  output pstc_pkg::side_t    side_out
);

  localparam int Steps  = pstc_pkg::DivSteps;
  localparam int Stages = Steps + 2;

  logic [Stages-1:0] v_r;
  logic [63:0]       dq_r  [Steps+1];
  logic [30:0]       rem_r [Steps+1];
  logic [30:0]       mb_r  [Steps+1];
  logic              neg_r [Steps+1];
  pstc_pkg::side_t   sd_r  [Steps+1];
  logic [63:0]       dq_nxt  [Steps];
  logic [30:0]       rem_nxt [Steps];
  logic [31:0]       trial   [Steps];
  logic [31:0]       diff    [Steps];
  logic              ge      [Steps];
  logic signed [63:0] quo_r;
  pstc_pkg::side_t   sdo_r;

  // One restoring step per stage: shift in a dividend bit, try a subtract.
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      trial[k]   = {rem_r[k], dq_r[k][63]};
      diff[k]    = trial[k] - {1'b0, mb_r[k]};
      ge[k]      = (trial[k] >= {1'b0, mb_r[k]});
      rem_nxt[k] = ge[k] ? diff[k][30:0] : trial[k][30:0];
      dq_nxt[k]  = {dq_r[k][62:0], ge[k]};
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      dq_r[0]  <= num[63] ? (~num + 64'd1) : num;
      rem_r[0] <= '0;
      mb_r[0]  <= den[30] ? (~den + 31'd1) : den;
      neg_r[0] <= num[63] ^ den[30];
      sd_r[0]  <= side_in;
      for (int k = 0; k < Steps; k++) begin
        dq_r[k+1]  <= dq_nxt[k];
        rem_r[k+1] <= rem_nxt[k];
        mb_r[k+1]  <= mb_r[k];
        neg_r[k+1] <= neg_r[k];
        sd_r[k+1]  <= sd_r[k];
      end
      quo_r <= neg_r[Steps] ? (~dq_r[Steps] + 64'd1) : dq_r[Steps];
      sdo_r <= sd_r[Steps];
    end
  end

  assign out_valid = v_r[Stages-1];
  assign quo       = quo_r;
  assign side_out  = sdo_r;

endmodule

@@ design/pstc_post.sv @@
// ----------------------------------------------------------------------------
// pstc_post: pressure correction pipeline
// Six stages applying the P7, P8 and P9 correction terms to the quotient in
// 64-bit modular arithmetic built from 32-bit partial products.
// ----------------------------------------------------------------------------
module pstc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [63:0] p,
  input  pstc_pkg::side_t    side_in,
  input  pstc_pkg::cal_t     cal,
  output logic               out_valid,
  output logic signed [63:0] f,
  output pstc_pkg::side_t    side_out
);

  localparam int Stages = 6;

  logic [Stages-1:0]  v_r;
  pstc_pkg::side_t    sd_r [Stages];
  logic signed [63:0] p_r  [4];

  logic signed [63:0] pr;
  logic [63:0]        ll_r, ll_nxt, lh_full;
  logic [31:0]        lh_r;
  logic signed [48:0] a8_r, a8_nxt, b8_full, a9_r, a9_nxt, b9_full;
  logic [31:0]        b8_r, b9_r;
  logic [63:0]        sq2_r, sq2_nxt;
  logic signed [63:0] p8p_r, p8p_nxt, w2p_r, w2p_nxt, w2p_c_r;
  logic signed [63:0] p9pp, w1p_r, w1p_nxt;
  logic signed [63:0] s_r, s_nxt, s_sh, f_r, f_nxt;

  always_comb begin
    // Square of the reduced quotient and the P8 term as partials.
    pr      = p >>> 13;
    ll_nxt  = pr[31:0] * pr[31:0];
    lh_full = pr[31:0] * pr[63:32];
    a8_nxt  = $signed({1'b0, p[31:0]}) * cal.p8;
    b8_full = $signed({1'b0, p[63:32]}) * cal.p8;
    sq2_nxt = ll_r + {lh_r[30:0], 33'h0};
    p8p_nxt = {{15{a8_r[48]}}, a8_r} + {b8_r, 32'h0};
    // P9 times the square, P8 term scaled down.
    a9_nxt  = $signed({1'b0, sq2_r[31:0]}) * cal.p9;
    b9_full = $signed({1'b0, sq2_r[63:32]}) * cal.p9;
    w2p_nxt = p8p_r >>> 19;
    p9pp    = {{15{a9_r[48]}}, a9_r} + {b9_r, 32'h0};
    w1p_nxt = p9pp >>> 25;
    // Final sum, scale and P7 offset.
    s_nxt   = p_r[3] + w1p_r + w2p_c_r;
    s_sh    = s_r >>> 8;
    f_nxt   = s_sh + ({{48{cal.p7[15]}}, cal.p7} << 4);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= ll_nxt;
      lh_r    <= lh_full[31:0];
      a8_r    <= a8_nxt;
      b8_r    <= b8_full[31:0];
      sq2_r   <= sq2_nxt;
      p8p_r   <= p8p_nxt;
      a9_r    <= a9_nxt;
      b9_r    <= b9_full[31:0];
      w2p_r   <= w2p_nxt;
      w1p_r   <= w1p_nxt;
      w2p_c_r <= w2p_r;
      s_r     <= s_nxt;
      f_r     <= f_nxt;
      p_r[0]  <= p;
      for (int i = 1; i < 4; i++) begin
        p_r[i] <= p_r[i-1];
      end
      sd_r[0] <= side_in;
      for (int i = 1; i < Stages; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  assign out_valid = v_r[Stages-1];
  assign f         = f_r;
  assign side_out  = sd_r[Stages-1];

endmodule

@@ design/pressure_temp_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_temp_sensor_compensation: barometric sensor compensation
// Integer compensation of raw temperature and pressure readings against
// twelve packed calibration coefficients, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one beat of raw temperature and pressure per clock unless
// halted and returns one beat of compensated temperature (centidegrees),
// pressure (Q24.8 pascals, saturated) and a divide error flag per input, in
// order. A beat passes 5 temperature stages, 7 coefficient stages, 66
// divider stages (one quotient bit per stage over 64 bits), 6 correction
// stages and the output register. The pipeline moves as a whole and halts
// only while its last stage and the output register both hold a result.
// Calibration registers must be written through the cfg port only while no
// beat is in flight (unenforced); writes to indexes above five are dropped.
module pressure_temp_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_divide_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  logic [31:0]        cal_t1_t2_r, cal_t3_p1_r, cal_p2_p3_r;
  logic [31:0]        cal_p4_p5_r, cal_p6_p7_r, cal_p8_p9_r;
  pstc_pkg::cal_t     cal;
  logic               en, slot_free;

  logic               temp_valid;
  logic signed [32:0] temp_x;
  logic signed [31:0] temp_tc;
  logic [19:0]        temp_rp;
  logic               coef_valid;
  logic [63:0]        coef_num;
  logic signed [30:0] coef_den;
  pstc_pkg::side_t    coef_side;
  logic               div_valid;
  logic signed [63:0] div_quo;
  pstc_pkg::side_t    div_side;
  logic               post_valid;
  logic signed [63:0] post_f;
  pstc_pkg::side_t    post_side;
  logic [31:0]        press_nxt;

  logic               out_valid_r;
  logic signed [31:0] out_tc_r;
  logic [31:0]        out_press_r;
  logic               out_err_r;

  // Calibration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t1_t2_r <= '0;
      cal_t3_p1_r <= '0;
      cal_p2_p3_r <= '0;
      cal_p4_p5_r <= '0;
      cal_p6_p7_r <= '0;
      cal_p8_p9_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pstc_pkg::REG_CAL_T1_T2: cal_t1_t2_r <= cfg_wdata;
        pstc_pkg::REG_CAL_T3_P1: cal_t3_p1_r <= cfg_wdata;
        pstc_pkg::REG_CAL_P2_P3: cal_p2_p3_r <= cfg_wdata;
        pstc_pkg::REG_CAL_P4_P5: cal_p4_p5_r <= cfg_wdata;
        pstc_pkg::REG_CAL_P6_P7: cal_p6_p7_r <= cfg_wdata;
        pstc_pkg::REG_CAL_P8_P9: cal_p8_p9_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the coefficient halves.
  always_comb begin
    cal.t1 = cal_t1_t2_r[15:0];
    cal.t2 = cal_t1_t2_r[31:16];
    cal.t3 = cal_t3_p1_r[15:0];
    cal.p1 = cal_t3_p1_r[31:16];
    cal.p2 = cal_p2_p3_r[15:0];
    cal.p3 = cal_p2_p3_r[31:16];
    cal.p4 = cal_p4_p5_r[15:0];
    cal.p5 = cal_p4_p5_r[31:16];
    cal.p6 = cal_p6_p7_r[15:0];
    cal.p7 = cal_p6_p7_r[31:16];
    cal.p8 = cal_p8_p9_r[15:0];
    cal.p9 = cal_p8_p9_r[31:16];
  end

  // The pipeline advances unless a finished result has nowhere to go.
  assign slot_free = !out_valid_r || out_ready;
  assign en        = !post_valid || slot_free;
  assign in_ready  = en;

  pstc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .raw_t     (in_raw_temperature),
    .raw_p     (in_raw_pressure),
    .cal       (cal),
    .out_valid (temp_valid),
    .x         (temp_x),
    .tcenti    (temp_tc),
    .rp        (temp_rp)
  );

  pstc_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (temp_valid),
    .x         (temp_x),
    .tcenti    (temp_tc),
    .rp        (temp_rp),
    .cal       (cal),
    .out_valid (coef_valid),
    .num       (coef_num),
    .den       (coef_den),
    .side      (coef_side)
  );

  pstc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (coef_valid),
    .num       (coef_num),
    .den       (coef_den),
    .side_in   (coef_side),
    .out_valid (div_valid),
    .quo       (div_quo),
    .side_out  (div_side)
  );

  pstc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .p         (div_quo),
    .side_in   (div_side),
    .cal       (cal),
    .out_valid (post_valid),
    .f         (post_f),
    .side_out  (post_side)
  );

  // Saturate to 32 bits unsigned; a zero divisor forces zero.
  always_comb begin
    priority if (post_side.err) begin
      press_nxt = '0;
    end else if (post_f[63]) begin
      press_nxt = '0;
    end else if (|post_f[62:32]) begin
      press_nxt = '1;
    end else begin
      press_nxt = post_f[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= post_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && post_valid) begin
      out_tc_r    <= post_side.tcenti;
      out_press_r <= press_nxt;
      out_err_r   <= post_side.err;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_tc_r;
  assign out_pressure_q24_8    = out_press_r;
  assign out_divide_error      = out_err_r;

  // A flagged beat never carries a pressure value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_press_r == '0)
    else $error("divide error beat with nonzero pressure");

  // Input is refused only when both the last stage and the output are full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> post_valid && out_valid_r && !out_ready)
    else $error("pipeline stalled without a blocked result");

  // A stalled result in the last stage is not dropped.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    post_valid && !en |=> post_valid)
    else $error("last stage result lost during stall");

  // Nothing comes out in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid_r && !post_valid)
    else $error("result present right after reset");

endmodule
